// ===== hdl/kss_pkg.sv =====
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants for the keyed signal statistics table.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int TableEntries = 32;
    localparam int ChannelLast  = 13;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int CountW       = $clog2(TableEntries + 1);
    localparam logic signed [7:0] LevelFloor = 8'sh80;

    typedef struct packed {
        logic              start_of_scan;
        logic [47:0]       station_key;
        logic [7:0]        radio_channel;
        logic signed [7:0] signal_level;
    } obs_t;

    typedef struct packed {
        logic [4:0]        entry_index;
        logic              was_present;
        logic              dropped;
        logic signed [7:0] level_min;
        logic signed [7:0] level_max;
        logic signed [7:0] channel_strongest;
    } result_t;

    // data handed from cell to cell along the chain
    typedef struct packed {
        logic              act;
        logic [47:0]       key;
        logic signed [7:0] level;
        logic              hit;
        logic [IdxW-1:0]   idx;
        logic signed [7:0] lo;
        logic signed [7:0] hi;
    } probe_t;

endpackage

// ===== hdl/keyed_signal_stats_table.sv =====
// ----------------------------------------------------------------------------
// keyed_signal_stats_table
// Station table with per-entry min/max and per-channel peak levels.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// in      | start, busy, obs                 | into block
// out     | result_valid, result             | out of block
//
// a transaction walks a chain of TableEntries cells, one cell per cycle;
// the result is registered from the chain tail in the done state.
// busy is high from acceptance until the result cycle, so a new item is
// accepted only once the previous one has finished.
// the receiver cannot stall; result is shown for exactly one cycle.
// reset clears the entry count and sets all channel peaks to -128.
// ----------------------------------------------------------------------------
module keyed_signal_stats_table
    import kss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  obs_t    obs,
    output logic    result_valid,
    output result_t result
);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

    state_t            state_reg;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] step_reg;
    obs_t              obs_reg;
    logic signed [7:0] peak_reg [ChannelLast+1];
    logic              result_valid_reg;
    result_t           result_reg;
    probe_t            chain [TableEntries+1];
    probe_t            head;
    probe_t            tail;
    logic              full;
    logic              chan_ok;
    logic signed [7:0] peak_cur;
    logic signed [7:0] peak_next;

    assign full    = (count_reg == CountW'(TableEntries));
    assign chan_ok = (obs_reg.radio_channel >= 8'd1) &&
                     (obs_reg.radio_channel <= 8'(ChannelLast));
    assign tail    = chain[TableEntries];

    // probe enters the chain in the cycle after acceptance
    always_comb
    begin
        head       = '0;
        head.act   = (state_reg == ST_WALK) && (step_reg == '0);
        head.key   = obs_reg.station_key;
        head.level = obs_reg.signal_level;
    end
    assign chain[0] = head;

    genvar g;
    generate
        for (g = 0; g < TableEntries; g++)
        begin : g_cell
            kss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IdxW'(g)),
                .filled    (count_reg > CountW'(g)),
                .append    (state_reg == ST_DONE && !tail.hit && !full &&
                            count_reg == CountW'(g)),
                .probe_in  ((state_reg == ST_DONE) ? tail : chain[g]),
                .probe_out (chain[g+1])
            );
        end
    endgenerate

    // channel peak after optional clear and update
    always_comb
    begin
        peak_cur = (obs_reg.start_of_scan) ? LevelFloor
                                           : peak_reg[obs_reg.radio_channel[3:0]];
        peak_next = (obs_reg.signal_level > peak_cur) ? obs_reg.signal_level : peak_cur;
    end

    // sequencer, table count, peaks and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            step_reg         <= '0;
            obs_reg          <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
            for (int c = 0; c <= ChannelLast; c++)
                peak_reg[c] <= LevelFloor;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        obs_reg   <= obs;
                        step_reg  <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == CountW'(TableEntries - 1))
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // this channel takes the new peak, the others clear on scan start
                    for (int c = 1; c <= ChannelLast; c++)
                    begin
                        if (chan_ok && obs_reg.radio_channel == 8'(c))
                            peak_reg[c] <= peak_next;
                        else if (obs_reg.start_of_scan)
                            peak_reg[c] <= LevelFloor;
                    end
                    if (!tail.hit && !full)
                        count_reg <= count_reg + 1'b1;
                    result_reg.was_present <= tail.hit;
                    result_reg.dropped     <= !tail.hit && full;
                    if (tail.hit)
                    begin
                        result_reg.entry_index <= 5'(tail.idx);
                        result_reg.level_min   <= tail.lo;
                        result_reg.level_max   <= tail.hi;
                    end
                    else if (full)
                    begin
                        result_reg.entry_index <= '0;
                        result_reg.level_min   <= '0;
                        result_reg.level_max   <= '0;
                    end
                    else
                    begin
                        result_reg.entry_index <= 5'(count_reg);
                        result_reg.level_min   <= obs_reg.signal_level;
                        result_reg.level_max   <= obs_reg.signal_level;
                    end
                    result_reg.channel_strongest <= chan_ok ? peak_next : LevelFloor;
                    result_valid_reg <= 1'b1;
                    state_reg        <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(TableEntries))
        else $error("entry count overflow");
    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_DONE))
        else $error("result without done");
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.was_present && result.dropped))
        else $error("hit and drop together");
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.dropped) |-> full)
        else $error("drop with room left");

endmodule

// ===== hdl/kss_cell.sv =====
// ----------------------------------------------------------------------------
// kss_cell
// One table entry: holds key and min/max, compares and updates in place.
// ----------------------------------------------------------------------------
module kss_cell
    import kss_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IdxW-1:0] cell_idx,
    input  logic            filled,
    input  logic            append,
    input  probe_t          probe_in,
    output probe_t          probe_out
);

    logic [47:0]       key_reg;
    logic signed [7:0] min_reg;
    logic signed [7:0] max_reg;
    logic              match;
    logic signed [7:0] lo_new;
    logic signed [7:0] hi_new;
    probe_t            probe_reg;
    probe_t            probe_next;

    // compare against this entry
    assign match  = probe_in.act && filled && !probe_in.hit && (key_reg == probe_in.key);
    assign lo_new = (probe_in.level < min_reg) ? probe_in.level : min_reg;
    assign hi_new = (probe_in.level > max_reg) ? probe_in.level : max_reg;

    always_comb
    begin
        probe_next = probe_in;
        if (match)
        begin
            probe_next.hit = 1'b1;
            probe_next.idx = cell_idx;
            probe_next.lo  = lo_new;
            probe_next.hi  = hi_new;
        end
    end

    // entry storage, updated on match or append
    always_ff @(posedge clk)
    begin
        if (append)
        begin
            key_reg <= probe_in.key;
            min_reg <= probe_in.level;
            max_reg <= probe_in.level;
        end
        else if (match)
        begin
            min_reg <= lo_new;
            max_reg <= hi_new;
        end
    end

    // hand the probe to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= '0;
        else
            probe_reg <= probe_next;
    end

    assign probe_out = probe_reg;

endmodule
